@@ hdl/lla_pkg.sv @@
// shared constants, cordic lane type and helper functions for the position converter
package lla_pkg;

   localparam int SQ_STEPS     = 32;
   localparam int CORDIC_STEPS = 28;
   localparam int DIV_STEPS    = 32;
   localparam int RL_STEPS     = 30;
   localparam int ACC_W        = 40;
   localparam int NORM_MSB     = 59;

   localparam longint unsigned E2_Q32 =
      (64'd595514000 * 64'd4294967296 + 64'd44478619024) / 64'd88957238049;
   localparam longint unsigned KOFF_Q16 =
      (64'd6371 * 64'd595514000 * 64'd65536 + 64'd44478619024) / 64'd88957238049;
   localparam longint unsigned RE_POLAR_Q16 =
      (64'd6378137 * 64'd297257 * 64'd65536 + 64'd149128500) / 64'd298257000;

   localparam logic signed [ACC_W-1:0] DEG90_Q30 = ACC_W'(64'd90 << 30);
   localparam logic signed [29:0] LON_MAX_Q20 = 30'(64'd180 << 20);
   localparam logic signed [29:0] LAT_MAX_Q20 = 30'(64'd90 << 20);

   typedef struct packed {
      logic signed [63:0]      x;
      logic signed [63:0]      y;
      logic signed [ACC_W-1:0] acc;
   } cordic_type;

   // restoring divide, only used while building constants
   function automatic longint unsigned lla_udiv(longint unsigned a, longint unsigned b);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], a[i]};
         if (r >= b) begin
            r = r - b;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(1/n) scaled by 2^62 from the alternating series
   function automatic longint unsigned lla_atan_inv(longint unsigned n);
      longint unsigned p;
      longint unsigned sum;
      longint unsigned k;
      longint unsigned n2;
      longint unsigned term;
      p = lla_udiv(64'd1 << 62, n);
      sum = 0;
      k = 0;
      n2 = n * n;
      while (p != 0) begin
         term = lla_udiv(p, 2 * k + 1);
         if (k[0] == 1'b0) sum = sum + term;
         else sum = sum - term;
         p = lla_udiv(p, n2);
         k = k + 1;
      end
      return sum;
   endfunction

   // atan(2^-i) in degrees, 30 fraction bits
   function automatic longint unsigned lla_angle_q30(int i);
      longint unsigned quarter;
      longint unsigned r;
      longint unsigned q;
      quarter = 4 * lla_atan_inv(64'd5) - lla_atan_inv(64'd239);
      if (i == 0) return 64'd45 << 30;
      r = lla_atan_inv(64'd1 << i);
      q = 0;
      for (int b = 0; b < 40; b++) begin
         r = r << 1;
         q = q << 1;
         if (r >= quarter) begin
            r = r - quarter;
            q = q | 64'd1;
         end
      end
      return (q * 45 + 512) >> 10;
   endfunction

   function automatic logic [5:0] lla_msb(logic [63:0] v);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) p = 6'(i);
      end
      return p;
   endfunction

   // round half up to 20 fraction bits, then clamp to +-lim
   function automatic logic signed [29:0] lla_round_clamp(logic signed [ACC_W-1:0] acc,
                                                         logic signed [29:0] lim);
      logic signed [ACC_W-1:0] s;
      logic signed [ACC_W-1:0] l;
      s = (acc + ACC_W'(512)) >>> 10;
      l = ACC_W'(lim);
      if (s > l) return lim;
      if (s < -l) return -lim;
      return 30'(s);
   endfunction

endpackage

@@ hdl/lla_delay.sv @@
// payload shift line of fixed depth
module lla_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] tap_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      tap_ff[0] <= din;
      for (int i = 1; i < DEPTH; i++) tap_ff[i] <= tap_ff[i-1];
   end

   assign dout = tap_ff[DEPTH-1];
endmodule

@@ hdl/lla_sqrt_cell.sv @@
// one digit step of the integer square root chain
module lla_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic        clock,
   input  logic [63:0] val_i,
   input  logic [63:0] root_i,
   output logic [63:0] val_o,
   output logic [63:0] root_o
);
   localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

   logic [63:0] val_in, root_in, val_ff, root_ff, trial;

   always_comb begin
      trial = root_i + BIT;
      if (val_i >= trial) begin
         val_in  = val_i - trial;
         root_in = (root_i >> 1) + BIT;
      end else begin
         val_in  = val_i;
         root_in = root_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      root_ff <= root_in;
   end

   assign val_o  = val_ff;
   assign root_o = root_ff;
endmodule

@@ hdl/lla_div_cell.sv @@
// one quotient bit of a restoring divide chain
module lla_div_cell #(
   parameter int RW = 64,
   parameter int QW = 32,
   parameter int FW = 32
) (
   input  logic          clock,
   input  logic [RW-1:0] rem_i,
   input  logic [RW-1:0] den_i,
   input  logic [QW-1:0] quo_i,
   input  logic [FW-1:0] feed_i,
   output logic [RW-1:0] rem_o,
   output logic [RW-1:0] den_o,
   output logic [QW-1:0] quo_o,
   output logic [FW-1:0] feed_o
);
   logic [RW-1:0] rem_in, rem_ff, den_ff, t;
   logic [QW-1:0] quo_in, quo_ff;
   logic [FW-1:0] feed_ff;

   always_comb begin
      t = {rem_i[RW-2:0], feed_i[FW-1]};
      if (t >= den_i) begin
         rem_in = t - den_i;
         quo_in = {quo_i[QW-2:0], 1'b1};
      end else begin
         rem_in = t;
         quo_in = {quo_i[QW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_i;
      quo_ff  <= quo_in;
      feed_ff <= {feed_i[FW-2:0], 1'b0};
   end

   assign rem_o  = rem_ff;
   assign den_o  = den_ff;
   assign quo_o  = quo_ff;
   assign feed_o = feed_ff;
endmodule

@@ hdl/lla_cordic_cell.sv @@
// one vectoring micro-rotation of the arctangent chain
module lla_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic               clock,
   input  lla_pkg::cordic_type lane_i,
   output lla_pkg::cordic_type lane_o
);
   import lla_pkg::*;

   localparam logic signed [ACC_W-1:0] ANGLE = ACC_W'(lla_angle_q30(STEP));

   cordic_type lane_in, lane_ff;
   logic signed [63:0] dx, dy;

   always_comb begin
      dx = lane_i.y >>> STEP;
      dy = lane_i.x >>> STEP;
      if (lane_i.y < 0) begin
         lane_in.x   = lane_i.x - dx;
         lane_in.y   = lane_i.y + dy;
         lane_in.acc = lane_i.acc - ANGLE;
      end else begin
         lane_in.x   = lane_i.x + dx;
         lane_in.y   = lane_i.y - dy;
         lane_in.acc = lane_i.acc + ANGLE;
      end
   end

   always_ff @(posedge clock) lane_ff <= lane_in;

   assign lane_o = lane_ff;
endmodule

@@ hdl/ecef_to_geodetic_lla.sv @@
// earth-fixed position to longitude, geodetic latitude and altitude, fully pipelined
//
//   channel   ports                      direction   handshake
//   request   req_pos_x/y/z, last_record in          start high, busy low
//   response  rsp_longitude .. last_out  out         rsp_valid, one cycle
//
// one item is taken every cycle; busy stays low
// each result leaves once its item has passed the divide, root and divide chains
// on the altitude path (32 + 32 + 30 cells plus seven set-up and output stages)
// reset clears only the valid line; payload cells need none
// the receiver cannot stall, results are shown for one cycle only
module ecef_to_geodetic_lla (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic        req_last_record,
   output logic        rsp_valid,
   output logic [28:0] rsp_longitude,
   output logic [27:0] rsp_latitude,
   output logic [31:0] rsp_altitude,
   output logic        rsp_invalid,
   output logic        rsp_last_out
);
   import lla_pkg::*;

   localparam int ST_ROOT = 3 + SQ_STEPS;          // rad and rxy
   localparam int ST_QUOT = 4 + DIV_STEPS;         // c quotient
   localparam int ST_U    = ST_QUOT + 1;
   localparam int ST_DQ   = ST_U + SQ_STEPS;
   localparam int ST_NUM  = ST_DQ + 1;
   localparam int ST_RL   = ST_NUM + RL_STEPS;
   localparam int ST_OUT  = ST_RL + 1;
   localparam int ST_LON  = 3 + CORDIC_STEPS + 1;
   localparam int ST_LATN = ST_ROOT + 4;           // normalised latitude operands
   localparam int ST_LAT  = ST_LATN + CORDIC_STEPS + 1;

   localparam logic [24:0] E2_C   = 25'(E2_Q32);
   localparam logic [31:0] KOFF_C = 32'(KOFF_Q16);
   localparam logic [63:0] NUM_C  = RE_POLAR_Q16 << 31;
   localparam logic [5:0]  NORM_C = 6'(NORM_MSB);

   logic accept;
   logic [ST_OUT:1] valid_ff;
   logic [ST_OUT:1] valid_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb valid_in = {valid_ff[ST_OUT-1:1], accept};

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= valid_in;
   end

   // stage 1: magnitudes and signs
   logic [31:0] ax_ff, ay_ff, az_ff, ax_in, ay_in, az_in;
   logic xneg_ff, yneg_ff, zneg_ff, last_ff;

   always_comb begin
      ax_in = req_pos_x[31] ? (32'd0 - req_pos_x) : req_pos_x;
      ay_in = req_pos_y[31] ? (32'd0 - req_pos_y) : req_pos_y;
      az_in = req_pos_z[31] ? (32'd0 - req_pos_z) : req_pos_z;
   end

   always_ff @(posedge clock) begin
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      az_ff   <= az_in;
      xneg_ff <= req_pos_x[31];
      yneg_ff <= req_pos_y[31];
      zneg_ff <= req_pos_z[31];
      last_ff <= req_last_record;
   end

   // stage 2: squares, longitude operand scan
   logic [63:0] sqx_ff, sqy_ff, sqz_ff;
   logic [31:0] lm_in, lxm_ff, lym_ff;
   logic [5:0]  lp_ff, lp_in;
   logic        lzero_ff, lxneg_ff, lyneg_ff;

   always_comb begin
      lm_in = (ay_ff > ax_ff) ? ay_ff : ax_ff;
      lp_in = lla_msb({32'd0, lm_in});
   end

   always_ff @(posedge clock) begin
      sqx_ff   <= 64'(ax_ff) * 64'(ax_ff);
      sqy_ff   <= 64'(ay_ff) * 64'(ay_ff);
      sqz_ff   <= 64'(az_ff) * 64'(az_ff);
      lxm_ff   <= ax_ff;
      lym_ff   <= ay_ff;
      lp_ff    <= lp_in;
      lzero_ff <= (lm_in == 32'd0);
      lxneg_ff <= xneg_ff;
      lyneg_ff <= yneg_ff;
   end

   // stage 3: sums, zero check, longitude normalise and half-plane fold
   logic [63:0] pxy_ff, rad2_ff, pxy_in, rad2_in;
   logic        inv_ff;
   cordic_type  lon_lane_in, lon_lane_ff;
   logic        lzero3_ff;
   logic signed [63:0] lx, ly;
   logic [63:0] lxs, lys;

   always_comb begin
      pxy_in  = sqx_ff + sqy_ff;
      rad2_in = pxy_in + sqz_ff;
      lxs = {32'd0, lxm_ff} << (NORM_C - lp_ff);
      lys = {32'd0, lym_ff} << (NORM_C - lp_ff);
      lx  = lxneg_ff ? -$signed(lxs) : $signed(lxs);
      ly  = lyneg_ff ? -$signed(lys) : $signed(lys);
      lon_lane_in.x   = lx;
      lon_lane_in.y   = ly;
      lon_lane_in.acc = '0;
      if (lx < 0) begin
         if (ly >= 0) begin
            lon_lane_in.x   = ly;
            lon_lane_in.y   = -lx;
            lon_lane_in.acc = DEG90_Q30;
         end else begin
            lon_lane_in.x   = -ly;
            lon_lane_in.y   = lx;
            lon_lane_in.acc = -DEG90_Q30;
         end
      end
   end

   always_ff @(posedge clock) begin
      pxy_ff      <= pxy_in;
      rad2_ff     <= rad2_in;
      inv_ff      <= (rad2_in == 64'd0);
      lon_lane_ff <= lon_lane_in;
      lzero3_ff   <= lzero_ff;
   end

   // longitude rotations
   cordic_type lon_lane [0:CORDIC_STEPS];
   assign lon_lane[0] = lon_lane_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_lon
      lla_cordic_cell #(.STEP(i)) u_cell (
         .clock (clock),
         .lane_i(lon_lane[i]),
         .lane_o(lon_lane[i+1])
      );
   end

   logic lzero_d;
   lla_delay #(.WIDTH(1), .DEPTH(CORDIC_STEPS)) u_lzero_d (
      .clock(clock), .din(lzero3_ff), .dout(lzero_d));

   logic signed [29:0] lon_ff, lon_in;
   always_comb lon_in = lzero_d ? '0 : lla_round_clamp(lon_lane[CORDIC_STEPS].acc, LON_MAX_Q20);
   always_ff @(posedge clock) lon_ff <= lon_in;

   // square roots of rad2 and pxy
   logic [63:0] rv [0:SQ_STEPS];
   logic [63:0] rr [0:SQ_STEPS];
   logic [63:0] pv [0:SQ_STEPS];
   logic [63:0] pr [0:SQ_STEPS];
   assign rv[0] = rad2_ff;
   assign rr[0] = '0;
   assign pv[0] = pxy_ff;
   assign pr[0] = '0;

   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_root
      lla_sqrt_cell #(.STEP(i)) u_rad (
         .clock(clock), .val_i(rv[i]), .root_i(rr[i]), .val_o(rv[i+1]), .root_o(rr[i+1]));
      lla_sqrt_cell #(.STEP(i)) u_rxy (
         .clock(clock), .val_i(pv[i]), .root_i(pr[i]), .val_o(pv[i+1]), .root_o(pr[i+1]));
   end

   logic [31:0] rad, rxy;
   assign rad = rr[SQ_STEPS][31:0];
   assign rxy = pr[SQ_STEPS][31:0];

   // stage 4: horizontal share set-up
   logic [63:0] dn_ff, dd_ff, dn_in, dd_in;
   logic        dge_ff;

   always_comb begin
      dn_in = pxy_ff;
      dd_in = rad2_ff;
      if (rad2_ff >= (64'd1 << 62)) begin
         dn_in = pxy_ff >> 2;
         dd_in = rad2_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      dn_ff  <= dn_in;
      dd_ff  <= dd_in;
      dge_ff <= (dn_in >= dd_in);
   end

   logic [63:0] cr [0:DIV_STEPS];
   logic [63:0] cd [0:DIV_STEPS];
   logic [31:0] cq [0:DIV_STEPS];
   logic [31:0] cf [0:DIV_STEPS];
   assign cr[0] = dn_ff;
   assign cd[0] = dd_ff;
   assign cq[0] = '0;
   assign cf[0] = '0;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cdiv
      lla_div_cell #(.RW(64), .QW(32), .FW(32)) u_cell (
         .clock(clock), .rem_i(cr[i]), .den_i(cd[i]), .quo_i(cq[i]), .feed_i(cf[i]),
         .rem_o(cr[i+1]), .den_o(cd[i+1]), .quo_o(cq[i+1]), .feed_o(cf[i+1]));
   end

   logic dge_d;
   lla_delay #(.WIDTH(1), .DEPTH(DIV_STEPS)) u_dge_d (
      .clock(clock), .din(dge_ff), .dout(dge_d));

   // u = 1 - e2 * c
   logic [32:0] c_in, u_ff, u_in;
   logic [57:0] e2c;

   always_comb begin
      c_in = dge_d ? 33'h1_0000_0000 : {1'b0, cq[DIV_STEPS]};
      e2c  = 58'(E2_C) * 58'(c_in);
      u_in = 33'h1_0000_0000 - 33'(e2c[57:32]);
   end

   always_ff @(posedge clock) u_ff <= u_in;

   logic [63:0] uv [0:SQ_STEPS];
   logic [63:0] ur [0:SQ_STEPS];
   assign uv[0] = {1'b0, u_ff, 30'd0};
   assign ur[0] = '0;

   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_uroot
      lla_sqrt_cell #(.STEP(i)) u_cell (
         .clock(clock), .val_i(uv[i]), .root_i(ur[i]), .val_o(uv[i+1]), .root_o(ur[i+1]));
   end

   // polar radius over the root, rounded by adding half the divisor
   logic [31:0] dq_fix;
   logic [63:0] num_in;
   logic [32:0] nr_ff, nd_ff;
   logic [29:0] nf_ff;

   always_comb begin
      dq_fix = (ur[SQ_STEPS][31:0] == 32'd0) ? 32'd1 : ur[SQ_STEPS][31:0];
      num_in = NUM_C + 64'(dq_fix >> 1);
   end

   always_ff @(posedge clock) begin
      nr_ff <= num_in[62:30];
      nd_ff <= {1'b0, dq_fix};
      nf_ff <= num_in[29:0];
   end

   logic [32:0] qr [0:RL_STEPS];
   logic [32:0] qd [0:RL_STEPS];
   logic [29:0] qq [0:RL_STEPS];
   logic [29:0] qf [0:RL_STEPS];
   assign qr[0] = nr_ff;
   assign qd[0] = nd_ff;
   assign qq[0] = '0;
   assign qf[0] = nf_ff;

   for (genvar i = 0; i < RL_STEPS; i++) begin : g_rdiv
      lla_div_cell #(.RW(33), .QW(30), .FW(30)) u_cell (
         .clock(clock), .rem_i(qr[i]), .den_i(qd[i]), .quo_i(qq[i]), .feed_i(qf[i]),
         .rem_o(qr[i+1]), .den_o(qd[i+1]), .quo_o(qq[i+1]), .feed_o(qf[i+1]));
   end

   // latitude operands
   logic [31:0] az_d;
   logic        zneg_d;
   lla_delay #(.WIDTH(32), .DEPTH(ST_ROOT - 1)) u_az_d (
      .clock(clock), .din(az_ff), .dout(az_d));
   lla_delay #(.WIDTH(1), .DEPTH(ST_LATN - 2)) u_zneg_d (
      .clock(clock), .din(zneg_ff), .dout(zneg_d));

   logic [63:0] tym_ff, tym2_ff, txm_ff, tym3_ff, txm3_ff;
   logic [31:0] dk_ff, trxy_ff, dk_in;
   logic [5:0]  tp_ff;
   logic        tzero_ff, tzero4_ff;
   logic [63:0] tm_in;
   cordic_type  lat_lane_in, lat_lane_ff;
   logic [63:0] txs, tys;

   always_comb dk_in = (rad >= KOFF_C) ? (rad - KOFF_C) : (KOFF_C - rad);

   always_comb begin
      tm_in = (tym2_ff > txm_ff) ? tym2_ff : txm_ff;
      if (tp_ff >= NORM_C) begin
         txs = txm3_ff >> (tp_ff - NORM_C);
         tys = tym3_ff >> (tp_ff - NORM_C);
      end else begin
         txs = txm3_ff << (NORM_C - tp_ff);
         tys = tym3_ff << (NORM_C - tp_ff);
      end
      lat_lane_in.x   = $signed(txs);
      lat_lane_in.y   = zneg_d ? -$signed(tys) : $signed(tys);
      lat_lane_in.acc = '0;
   end

   always_ff @(posedge clock) begin
      tym_ff      <= 64'(az_d) * 64'(rad);
      dk_ff       <= dk_in;
      trxy_ff     <= rxy;
      txm_ff      <= 64'(dk_ff) * 64'(trxy_ff);
      tym2_ff     <= tym_ff;
      tp_ff       <= lla_msb(tm_in);
      tzero_ff    <= (tm_in == 64'd0);
      txm3_ff     <= txm_ff;
      tym3_ff     <= tym2_ff;
      lat_lane_ff <= lat_lane_in;
      tzero4_ff   <= tzero_ff;
   end

   cordic_type lat_lane [0:CORDIC_STEPS];
   assign lat_lane[0] = lat_lane_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_lat
      lla_cordic_cell #(.STEP(i)) u_cell (
         .clock (clock),
         .lane_i(lat_lane[i]),
         .lane_o(lat_lane[i+1])
      );
   end

   logic tzero_d;
   lla_delay #(.WIDTH(1), .DEPTH(CORDIC_STEPS)) u_tzero_d (
      .clock(clock), .din(tzero4_ff), .dout(tzero_d));

   logic signed [29:0] lat_ff, lat_in;
   always_comb lat_in = tzero_d ? '0 : lla_round_clamp(lat_lane[CORDIC_STEPS].acc, LAT_MAX_Q20);
   always_ff @(posedge clock) lat_ff <= lat_in;

   // align everything to the output stage
   logic [31:0] rad_d;
   logic [29:0] lon_d, lat_d;
   logic        inv_d, last_d;

   lla_delay #(.WIDTH(32), .DEPTH(ST_RL - ST_ROOT)) u_rad_d (
      .clock(clock), .din(rad), .dout(rad_d));
   lla_delay #(.WIDTH(30), .DEPTH(ST_RL - ST_LON)) u_lon_d (
      .clock(clock), .din(lon_ff), .dout(lon_d));
   lla_delay #(.WIDTH(30), .DEPTH(ST_RL - ST_LAT)) u_lat_d (
      .clock(clock), .din(lat_ff), .dout(lat_d));
   lla_delay #(.WIDTH(1), .DEPTH(ST_RL - 3)) u_inv_d (
      .clock(clock), .din(inv_ff), .dout(inv_d));
   lla_delay #(.WIDTH(1), .DEPTH(ST_RL - 1)) u_last_d (
      .clock(clock), .din(last_ff), .dout(last_d));

   logic signed [33:0] alt_diff;
   logic [31:0] alt_in, alt_ff;
   logic [28:0] lon_out_ff;
   logic [27:0] lat_out_ff;
   logic        inv_out_ff, last_out_ff;

   always_comb begin
      alt_diff = $signed({2'b00, rad_d}) - $signed({4'b0000, qq[RL_STEPS]});
      if (alt_diff > 34'sh0_7FFF_FFFF) alt_in = 32'h7FFF_FFFF;
      else if (alt_diff < -34'sh0_8000_0000) alt_in = 32'h8000_0000;
      else alt_in = alt_diff[31:0];
   end

   always_ff @(posedge clock) begin
      alt_ff      <= inv_d ? '0 : alt_in;
      lon_out_ff  <= inv_d ? '0 : lon_d[28:0];
      lat_out_ff  <= inv_d ? '0 : lat_d[27:0];
      inv_out_ff  <= inv_d;
      last_out_ff <= last_d;
   end

   assign rsp_valid     = valid_ff[ST_OUT];
   assign rsp_longitude = lon_out_ff;
   assign rsp_latitude  = lat_out_ff;
   assign rsp_altitude  = alt_ff;
   assign rsp_invalid   = inv_out_ff;
   assign rsp_last_out  = last_out_ff;

`ifndef SYNTHESIS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##ST_OUT rsp_valid)
      else $error("item did not come out after the pipeline depth");

   a_zero_on_invalid : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |->
         (rsp_longitude == '0 && rsp_latitude == '0 && rsp_altitude == '0))
      else $error("invalid item with non-zero fields");

   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_latitude) <= $signed(LAT_MAX_Q20[27:0]) &&
                     $signed(rsp_latitude) >= -$signed(LAT_MAX_Q20[27:0]) &&
                     $signed(rsp_longitude) <= $signed(LON_MAX_Q20[28:0]) &&
                     $signed(rsp_longitude) >= -$signed(LON_MAX_Q20[28:0])))
      else $error("angle outside its range");
`endif
endmodule

@@ bench/ecef_to_geodetic_lla_tb.sv @@
// self-checking testbench for the earth-fixed position to longitude/latitude/altitude converter
`timescale 1ns / 1ps

module ecef_to_geodetic_lla_tb;

   localparam int LATENCY   = 101;
   localparam int N_RANDOM  = 930;
   localparam int MAX_CYCLE = 200000;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        last;
   } pos_item_type;

   typedef struct {
      logic [28:0] lon;
      logic [27:0] lat;
      logic [31:0] alt;
      logic        inv;
      logic        last;
   } geo_type;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        last;
      logic        typed;
      geo_type     res;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_pos_x = '0;
   logic [31:0] req_pos_y = '0;
   logic [31:0] req_pos_z = '0;
   logic        req_last_record = 1'b0;
   logic        rsp_valid;
   logic [28:0] rsp_longitude;
   logic [27:0] rsp_latitude;
   logic [31:0] rsp_altitude;
   logic        rsp_invalid;
   logic        rsp_last_out;

   ecef_to_geodetic_lla u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_last_record(req_last_record),
      .rsp_valid(rsp_valid), .rsp_longitude(rsp_longitude), .rsp_latitude(rsp_latitude),
      .rsp_altitude(rsp_altitude), .rsp_invalid(rsp_invalid), .rsp_last_out(rsp_last_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   localparam longint unsigned ECC_Q32 =
      (64'd595514000 * 64'd4294967296 + 64'd44478619024) / 64'd88957238049;
   localparam longint unsigned K_OFS_Q16 =
      (64'd6371 * 64'd595514000 * 64'd65536 + 64'd44478619024) / 64'd88957238049;
   localparam longint unsigned POLAR_Q16 =
      (64'd6378137 * 64'd297257 * 64'd65536 + 64'd149128500) / 64'd298257000;
   localparam longint QTR_TURN_Q30 = 64'd90 << 30;

   longint atan_deg_q30 [28];

   function automatic longint unsigned arctan_recip(longint unsigned n);
      longint unsigned p, sum, k, n2, term;
      p = (64'd1 << 62) / n;
      sum = 0;
      k = 0;
      n2 = n * n;
      while (p != 0) begin
         term = p / (2 * k + 1);
         if (k[0] == 1'b0) sum = sum + term;
         else sum = sum - term;
         p = p / n2;
         k = k + 1;
      end
      return sum;
   endfunction

   task automatic fill_atan_table();
      longint unsigned quarter, r, q;
      quarter = 4 * arctan_recip(5) - arctan_recip(239);
      atan_deg_q30[0] = 64'd45 << 30;
      for (int i = 1; i < 28; i++) begin
         r = arctan_recip(64'd1 << i);
         q = 0;
         for (int b = 0; b < 40; b++) begin
            r = r << 1;
            q = q << 1;
            if (r >= quarter) begin
               r = r - quarter;
               q = q | 64'd1;
            end
         end
         atan_deg_q30[i] = longint'((q * 45 + 512) >> 10);
      end
   endtask

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // vectoring rotation, angle in degrees q20 before clamping
   function automatic longint vector_angle(bit yneg, longint unsigned ym, bit xneg,
                                           longint unsigned xm);
      longint unsigned m;
      longint cx, cy, acc, t, dx, dy;
      m = (ym > xm) ? ym : xm;
      acc = 0;
      if (m == 0) return 0;
      while (m >= (64'd1 << 60)) begin
         m = m >> 1; xm = xm >> 1; ym = ym >> 1;
      end
      while (m < (64'd1 << 59)) begin
         m = m << 1; xm = xm << 1; ym = ym << 1;
      end
      cx = xneg ? -longint'(xm) : longint'(xm);
      cy = yneg ? -longint'(ym) : longint'(ym);
      if (cx < 0) begin
         if (cy >= 0) begin
            t = cx; cx = cy; cy = -t; acc = QTR_TURN_Q30;
         end else begin
            t = cx; cx = -cy; cy = t; acc = -QTR_TURN_Q30;
         end
      end
      for (int i = 0; i < 28; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cy < 0) begin
            cx = cx - dx; cy = cy + dy; acc = acc - atan_deg_q30[i];
         end else begin
            cx = cx + dx; cy = cy - dy; acc = acc + atan_deg_q30[i];
         end
      end
      return (acc + 512) >>> 10;
   endfunction

   function automatic longint limit_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic geo_type predict_geo(pos_item_type p);
      geo_type g;
      longint x, y, z, lon, lat, alt;
      longint unsigned ax, ay, az, pxy, rad2, rad, rxy, dk, n, d, c, u, dq, rl;
      x = longint'(signed'(p.x));
      y = longint'(signed'(p.y));
      z = longint'(signed'(p.z));
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      pxy = ax * ax + ay * ay;
      rad2 = pxy + az * az;
      g.last = p.last;
      if (rad2 == 0) begin
         g.lon = '0; g.lat = '0; g.alt = '0; g.inv = 1'b1;
         return g;
      end
      lon = limit_sym(vector_angle(y < 0, ay, x < 0, ax), 64'd180 << 20);
      rad = int_sqrt(rad2);
      rxy = int_sqrt(pxy);
      dk = (rad >= K_OFS_Q16) ? rad - K_OFS_Q16 : K_OFS_Q16 - rad;
      lat = limit_sym(vector_angle(z < 0, az * rad, 1'b0, dk * rxy), 64'd90 << 20);
      n = pxy;
      d = rad2;
      if (d >= (64'd1 << 62)) begin
         n = n >> 2; d = d >> 2;
      end
      if (n >= d) begin
         c = 64'd1 << 32;
      end else begin
         c = 0;
         for (int b = 0; b < 32; b++) begin
            n = n << 1; c = c << 1;
            if (n >= d) begin
               n = n - d; c = c | 64'd1;
            end
         end
      end
      u = (64'd1 << 32) - ((ECC_Q32 * c) >> 32);
      dq = int_sqrt(u << 30);
      if (dq == 0) dq = 1;
      // the scaled polar radius stays below 2^60
      rl = ((POLAR_Q16 << 31) + dq / 2) / dq;
      alt = longint'(rad) - longint'(rl);
      if (alt > 64'sd2147483647) alt = 64'sd2147483647;
      if (alt < -64'sd2147483648) alt = -64'sd2147483648;
      g.lon = lon[28:0];
      g.lat = lat[27:0];
      g.alt = alt[31:0];
      g.inv = 1'b0;
      return g;
   endfunction

   pos_item_type pos_items[$];
   geo_type      geo_pending[$];
   logic         typed_pending[$];
   dir_row_type  dir_rows[$];
   int           mismatch_count = 0;
   int           cycle_count = 0;

   function automatic dir_row_type mk_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                          logic last);
      dir_row_type r;
      r.x = x; r.y = y; r.z = z; r.last = last; r.typed = 1'b0;
      r.res = '{lon: '0, lat: '0, alt: '0, inv: 1'b0, last: last};
      return r;
   endfunction

   task automatic build_directed();
      dir_row_type r;
      int unsigned ko;
      ko = int'(K_OFS_Q16);
      // zero-length vector, results typed in
      r = mk_row(0, 0, 0, 0); r.typed = 1'b1; r.res.inv = 1'b1; dir_rows.push_back(r);
      r = mk_row(0, 0, 0, 1); r.typed = 1'b1; r.res.inv = 1'b1; dir_rows.push_back(r);
      dir_rows.push_back(mk_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1));
      dir_rows.push_back(mk_row(32'h80000000, 32'h80000000, 32'h80000000, 0));
      dir_rows.push_back(mk_row(32'h80000000, 0, 0, 0));
      dir_rows.push_back(mk_row(32'h7fffffff, 0, 0, 1));
      dir_rows.push_back(mk_row(0, 32'h7fffffff, 0, 0));
      dir_rows.push_back(mk_row(0, 32'h80000000, 0, 0));
      // z axis, both poles
      dir_rows.push_back(mk_row(0, 0, 32'h18e6_0000, 0));
      dir_rows.push_back(mk_row(0, 0, 32'he71a_0000, 1));
      dir_rows.push_back(mk_row(0, 0, 1, 0));
      dir_rows.push_back(mk_row(0, 0, 32'h80000000, 0));
      // negative x axis, longitude near the clamp
      dir_rows.push_back(mk_row(-32'sd418000000, 0, 0, 0));
      dir_rows.push_back(mk_row(32'hffffffff, 0, 0, 0));
      dir_rows.push_back(mk_row(-32'sd418000000, 32'hffffffff, 0, 0));
      // radius equal to the latitude offset with z zero
      dir_rows.push_back(mk_row(ko, 0, 0, 0));
      dir_rows.push_back(mk_row(0, ko, 0, 1));
      dir_rows.push_back(mk_row(1, 0, 0, 0));
      dir_rows.push_back(mk_row(1, 1, 1, 0));
      dir_rows.push_back(mk_row(32'h18e6_0000, 32'h18e6_0000, 32'h18e6_0000, 0));
      dir_rows.push_back(mk_row(32'h8000_0001, 32'h7fff_ffff, 32'h0000_0001, 1));
      dir_rows.push_back(mk_row(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 0));
      dir_rows.push_back(mk_row(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1));
   endtask

   function automatic logic [31:0] earth_coord();
      int v;
      v = $urandom_range(900000000) - 450000000;
      return v;
   endfunction

   task automatic build_random();
      pos_item_type p;
      int unsigned kind;
      for (int i = 0; i < N_RANDOM; i++) begin
         kind = $urandom_range(99);
         p.last = $urandom_range(1);
         if (kind < 55) begin
            p.x = earth_coord(); p.y = earth_coord(); p.z = earth_coord();
         end else if (kind < 80) begin
            p.x = $urandom; p.y = $urandom; p.z = $urandom;
         end else if (kind < 90) begin
            p.x = $signed($urandom_range(2000)) - 1000;
            p.y = $signed($urandom_range(2000)) - 1000;
            p.z = $signed($urandom_range(2000)) - 1000;
         end else begin
            // axis and near-axis points
            p.x = ($urandom_range(1)) ? earth_coord() : 32'h0;
            p.y = ($urandom_range(1)) ? 32'h0 : 32'($urandom_range(3));
            p.z = ($urandom_range(2) == 0) ? 32'h0 : earth_coord();
         end
         pos_items.push_back(p);
      end
   endtask

   // result check
   always @(posedge clock) begin
      geo_type e;
      logic typed;
      if (!reset && rsp_valid) begin
         if (geo_pending.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result lon=%h", rsp_longitude);
         end else begin
            e = geo_pending.pop_front();
            typed = typed_pending.pop_front();
            if (rsp_longitude !== e.lon || rsp_latitude !== e.lat ||
                rsp_altitude !== e.alt || rsp_invalid !== e.inv ||
                rsp_last_out !== e.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch%s: exp lon=%h lat=%h alt=%h inv=%b last=%b,",
                           typed ? " (typed)" : "", e.lon, e.lat, e.alt, e.inv, e.last,
                           " got lon=%h lat=%h alt=%h inv=%b last=%b",
                           rsp_longitude, rsp_latitude, rsp_altitude, rsp_invalid,
                           rsp_last_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= MAX_CYCLE) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      pos_item_type p;
      geo_type g;
      logic typed;
      int burst, idx;
      fill_atan_table();
      build_directed();
      foreach (dir_rows[i]) begin
         p = '{x: dir_rows[i].x, y: dir_rows[i].y, z: dir_rows[i].z, last: dir_rows[i].last};
         pos_items.push_back(p);
      end
      build_random();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      idx = 0;
      burst = 0;
      @(posedge clock);
      while (idx < pos_items.size() || start) begin
         if (start && !busy) begin
            p = '{x: req_pos_x, y: req_pos_y, z: req_pos_z, last: req_last_record};
            typed = (idx <= dir_rows.size()) && dir_rows[idx-1].typed;
            g = typed ? dir_rows[idx-1].res : predict_geo(p);
            geo_pending.push_back(g);
            typed_pending.push_back(typed);
         end
         if (!start || !busy) begin
            if (burst == 0) burst = ($urandom_range(3) == 0) ? -$urandom_range(1, 6)
                                                               : $urandom_range(1, 40);
            if (burst < 0 || idx >= pos_items.size()) begin
               start <= 1'b0;
               if (burst < 0) burst++;
            end else begin
               start <= 1'b1;
               req_pos_x <= pos_items[idx].x;
               req_pos_y <= pos_items[idx].y;
               req_pos_z <= pos_items[idx].z;
               req_last_record <= pos_items[idx].last;
               idx++;
               burst--;
            end
         end
         @(posedge clock);
      end
      while (geo_pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatch_count == 0 && geo_pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
